/* hw/rtl/swegc_pkg.sv */
// shared types, widths and codes for the sliding-window entropy and gc block
// used by the controller, the datapath and its arithmetic units
package swegc_pkg;

  // default history depth
  localparam int unsigned MAX_WINDOW_DEF = 256;

  // item fields
  localparam int unsigned BASE_W      = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned ENT_W       = 16;
  localparam int unsigned GC_W        = 17;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - POS_W - ENT_W - GC_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WL_W       = 8;
  localparam int unsigned SL_W       = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEQUENCE_LENGTH = 1'b1;
  localparam logic [WL_W-1:0]       WL_RESET            = 8'd100;
  localparam logic [SL_W-1:0]       SL_RESET            = 32'd1;

  // base counts
  localparam int unsigned NUM_BASES = 4;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned CG_W      = 9;
  localparam int unsigned WCALC_W   = 9;

  // log2 unit: q4.24 result from a q1.30 mantissa
  localparam int unsigned IP_W      = 4;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned LOG_W     = IP_W + FRAC_W;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned MANT_FRAC = MANT_W - 1;
  localparam int unsigned LOG_CNT_W = 5;

  // entropy sums and division
  localparam int unsigned PROD_W          = SUM_W + LOG_W;
  localparam int unsigned TSUM_W          = PROD_W + 1;
  localparam int unsigned ENT_ROUND_SHIFT = 9;
  localparam int unsigned ENT_SHIFT       = 10;
  localparam int unsigned DIV_NUM_W       = TSUM_W - ENT_SHIFT;
  localparam int unsigned DIV_CNT_W       = 5;
  localparam int unsigned GC_FRAC         = 16;
  localparam int unsigned GC_NUM_W        = CG_W + GC_FRAC;
  localparam logic [ENT_W-1:0] ENT_MAX    = 16'd32768;

  // term sequence: four base counts, then the window sum
  localparam int unsigned TERM_W = 3;
  localparam logic [TERM_W-1:0] TERM_FIRST = 3'd0;
  localparam logic [TERM_W-1:0] TERM_SUM   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic              accept;
    logic              prep;
    logic              select;
    logic              log_start;
    logic [TERM_W-1:0] term;
    logic              mul;
    logic              acc;
    logic              tdiff;
    logic              div_start;
    logic              div_gc;
    logic              store_ent;
    logic              store_gc;
    logic              load_lo;
    logic              load_hi;
    logic              finish;
  } swegc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic win;
    logic emit_lo;
    logic emit_hi;
    logic log_done;
    logic div_done;
    logic out_free;
  } swegc_sts_t;

endpackage

/* hw/rtl/sliding_window_base_entropy_gc_top.sv */
// Sliding-window base entropy and gc fraction, top level.
// Input channel s_axis: one base per item, tdata[1:0] = A/C/G/T as 0..3.
// Output channel m_axis: up to two results per base; tdata holds position,
// entropy (unsigned q2.14) and gc fraction (q1.16), tlast marks the final
// result that a base causes. Registers are written on cfg_we_i at any edge:
// index 0 window length (reset 100), index 1 sequence length (reset 1).
// One base is worked on at a time. A base whose window is not yet full only
// passes through prep, select and finish. A full window runs five log2
// evaluations of 24 squarings each on one shared 31x31 multiplier, then two
// 29-step restoring divisions for entropy and gc.
// Results leave through a single output register; while the receiver stalls
// with a result waiting, the sequencer holds before loading the next one, and
// the input stays closed until the current base has finished.
// Reset clears the counts, the position and the output valid; the history
// memory needs no clearing pass, as only entries of the current stream are read.
// Depends on swegc_pkg, swegc_ctrl, swegc_dp, swegc_log2 and swegc_div.
module sliding_window_base_entropy_gc_top import swegc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] base
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] position, [47:32] entropy,
                                                // [64:48] gc_fraction
  output logic                   m_axis_tlast   // last_of_run
);

  swegc_cmd_t cmd;
  swegc_sts_t sts;

  // sequencer
  swegc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  swegc_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .base_i      (s_axis_tdata[BASE_W-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* hw/rtl/swegc_log2.sv */
// iterative fixed-point log2 of a 10-bit integer, 24 fraction bits
// one squaring of the mantissa per cycle; depends on swegc_pkg
module swegc_log2 import swegc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] x_i,
  output logic             done_o,
  output logic [LOG_W-1:0] log_o
);

  logic                     busy_q;
  logic                     done_q;
  logic [LOG_CNT_W-1:0]     cnt_q;
  logic [MANT_W-1:0]        m_q;
  logic [FRAC_W-1:0]        frac_q;
  logic [IP_W-1:0]          ip_q;

  logic [IP_W-1:0]          ip_init;
  logic [SUM_W+MANT_FRAC-1:0] shifted;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          msh;
  logic [MANT_W-1:0]        m_next;

  // index of the top set bit
  always_comb begin
    ip_init = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (x_i[i]) begin
        ip_init = IP_W'(i);
      end
    end
  end

  // normalise into [1,2) as q1.30
  assign shifted = {x_i, {MANT_FRAC{1'b0}}} >> ip_init;

  // square and renormalise
  assign sq     = m_q * m_q;
  assign msh    = sq[2*MANT_W-1:MANT_FRAC];
  assign m_next = msh[MANT_W] ? msh[MANT_W:1] : msh[MANT_W-1:0];

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= LOG_CNT_W'(FRAC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - LOG_CNT_W'(1);
        if (cnt_q == LOG_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // mantissa and fraction bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= shifted[MANT_W-1:0];
      ip_q   <= ip_init;
      frac_q <= '0;
    end else if (busy_q) begin
      m_q    <= m_next;
      frac_q <= {frac_q[FRAC_W-2:0], msh[MANT_W]};
    end
  end

  assign done_o = done_q;
  assign log_o  = {ip_q, frac_q};

endmodule

/* hw/rtl/swegc_div.sv */
// restoring divider, one quotient bit per cycle
// 29-bit dividend over a 10-bit divisor; depends on swegc_pkg
module swegc_div import swegc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0]     den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     den_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;
  logic                 fits;

  // one trial subtraction
  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/swegc_dp.sv */
// datapath: config registers, base history, counts, entropy and gc arithmetic
// and the output register; uses swegc_pkg, swegc_log2 and swegc_div
module swegc_dp import swegc_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swegc_cmd_t             cmd_i,
  output swegc_sts_t             sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [BASE_W-1:0]      base_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DW = $clog2(2 * MAX_WINDOW);

  // configuration and stream position
  logic [WL_W-1:0]   wl_q;
  logic [SL_W-1:0]   sl_q;
  logic [POS_W-1:0]  j_q;
  logic [AW-1:0]     wr_ptr_q;
  logic [CNT_W-1:0]  cnt_q [NUM_BASES];

  // per-item decisions
  logic [WW-1:0]     w_q;
  logic [POS_W-1:0]  p_q;
  logic [AW-1:0]     rd_ptr_q;
  logic              win_q;
  logic              emit_lo_q;
  logic              emit_hi_q;

  // history memory
  logic [BASE_W-1:0] hist_mem [MAX_WINDOW];
  logic [BASE_W-1:0] hist_rd_q;

  // arithmetic
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] pos_q;
  logic [PROD_W-1:0] neg_q;
  logic [PROD_W-1:0] t_q;
  logic [ENT_W-1:0]  ent_q;
  logic [GC_W-1:0]   gc_q;

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;

  logic [SL_W-2:0]      mid;
  logic [WL_W-1:0]      w_mid;
  logic [WCALC_W-1:0]   w_cap;
  logic [WW-1:0]        w_eff;
  logic [WW-1:0]        w_m1;
  logic [DW-1:0]        rd_sum;
  logic [SUM_W-1:0]     s;
  logic [CG_W-1:0]      cg;
  logic [SUM_W-1:0]     operand;
  logic                 log_done;
  logic [LOG_W-1:0]     log_res;
  logic [TSUM_W-1:0]    ent_sum;
  logic [GC_NUM_W-1:0]  gc_num;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quo;

  assign mid = sl_q[SL_W-1:1];

  // effective window: min of request, midpoint and depth, at least one
  always_comb begin
    w_mid = (mid < (SL_W-1)'(wl_q)) ? mid[WL_W-1:0] : wl_q;
    w_cap = ({1'b0, w_mid} > WCALC_W'(MAX_WINDOW)) ? WCALC_W'(MAX_WINDOW) : {1'b0, w_mid};
    w_eff = (w_cap == '0) ? WW'(1) : w_cap[WW-1:0];
  end

  // oldest slot of the window, modulo the depth
  assign w_m1   = w_q - WW'(1);
  assign rd_sum = DW'(wr_ptr_q) + DW'(MAX_WINDOW) - DW'(w_m1);

  // window totals
  assign s  = SUM_W'(cnt_q[0]) + SUM_W'(cnt_q[1]) + SUM_W'(cnt_q[2]) + SUM_W'(cnt_q[3]);
  assign cg = CG_W'(cnt_q[1]) + CG_W'(cnt_q[2]);

  // operand of the current entropy term
  assign operand = (cmd_i.term == TERM_SUM) ? s : SUM_W'(cnt_q[cmd_i.term[1:0]]);

  swegc_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .x_i     (operand),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  // dividend for entropy (with rounding) or gc fraction
  assign ent_sum = TSUM_W'(t_q) + (TSUM_W'(s) << ENT_ROUND_SHIFT);
  assign gc_num  = {cg, {GC_FRAC{1'b0}}} + GC_NUM_W'(s[SUM_W-1:1]);
  assign div_num = cmd_i.div_gc ? DIV_NUM_W'(gc_num) : ent_sum[TSUM_W-1:ENT_SHIFT];

  swegc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (s),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // control state: config, counts, position, decisions, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q        <= WL_RESET;
      sl_q        <= SL_RESET;
      j_q         <= '0;
      wr_ptr_q    <= '0;
      for (int k = 0; k < NUM_BASES; k++) begin
        cnt_q[k] <= '0;
      end
      win_q       <= 1'b0;
      emit_lo_q   <= 1'b0;
      emit_hi_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_WINDOW_LENGTH:   wl_q <= cfg_wdata_i[WL_W-1:0];
          CFG_SEQUENCE_LENGTH: sl_q <= cfg_wdata_i[SL_W-1:0];
          default: ;
        endcase
      end
      // new base enters the window
      if (cmd_i.accept && cnt_q[base_i] != '1) begin
        cnt_q[base_i] <= cnt_q[base_i] + CNT_W'(1);
      end
      if (cmd_i.prep) begin
        win_q     <= j_q >= POS_W'(w_m1);
        emit_hi_q <= j_q >= {1'b0, mid};
      end
      if (cmd_i.select) begin
        emit_lo_q <= p_q < {1'b0, mid};
      end
      // oldest base leaves, position moves on
      if (cmd_i.finish) begin
        if (win_q && cnt_q[hist_rd_q] != '0) begin
          cnt_q[hist_rd_q] <= cnt_q[hist_rd_q] - CNT_W'(1);
        end
        j_q <= j_q + POS_W'(1);
        if (j_q == '1 || wr_ptr_q == AW'(MAX_WINDOW - 1)) begin
          wr_ptr_q <= '0;
        end else begin
          wr_ptr_q <= wr_ptr_q + AW'(1);
        end
      end
      // output handshake
      if (cmd_i.load_lo || cmd_i.load_hi) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // history memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hist_mem[wr_ptr_q] <= base_i;
    end
    if (cmd_i.select) begin
      hist_rd_q <= hist_mem[rd_ptr_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      w_q <= w_eff;
    end
    if (cmd_i.prep) begin
      p_q      <= j_q - POS_W'(w_m1);
      rd_ptr_q <= (rd_sum >= DW'(MAX_WINDOW)) ? AW'(rd_sum - DW'(MAX_WINDOW)) : AW'(rd_sum);
    end
    if (cmd_i.select) begin
      neg_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= operand * log_res;
    end
    if (cmd_i.acc) begin
      if (cmd_i.term == TERM_SUM) begin
        pos_q <= prod_q;
      end else begin
        neg_q <= neg_q + prod_q;
      end
    end
    if (cmd_i.tdiff) begin
      t_q <= (pos_q > neg_q) ? pos_q - neg_q : '0;
    end
    if (cmd_i.store_ent) begin
      ent_q <= (quo > DIV_NUM_W'(ENT_MAX)) ? ENT_MAX : quo[ENT_W-1:0];
    end
    if (cmd_i.store_gc) begin
      gc_q <= quo[GC_W-1:0];
    end
    if (cmd_i.load_lo) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, gc_q, ent_q, p_q};
      out_last_q <= !emit_hi_q;
    end else if (cmd_i.load_hi) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, gc_q, ent_q, j_q};
      out_last_q <= 1'b1;
    end
  end

  // status back to the controller
  assign sts_o.win      = win_q;
  assign sts_o.emit_lo  = emit_lo_q;
  assign sts_o.emit_hi  = emit_hi_q;
  assign sts_o.log_done = log_done;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/swegc_ctrl.sv */
// controller state machine sequencing one item through the datapath
// issues swegc_cmd_t and reads swegc_sts_t; depends on swegc_pkg
module swegc_ctrl import swegc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  swegc_sts_t sts_i,
  output swegc_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PREP      = 4'd1;
  localparam logic [3:0] S_SELECT    = 4'd2;
  localparam logic [3:0] S_LOG_GO    = 4'd3;
  localparam logic [3:0] S_LOG_WAIT  = 4'd4;
  localparam logic [3:0] S_MUL       = 4'd5;
  localparam logic [3:0] S_ACC       = 4'd6;
  localparam logic [3:0] S_TDIFF     = 4'd7;
  localparam logic [3:0] S_DIVE_GO   = 4'd8;
  localparam logic [3:0] S_DIVE_WAIT = 4'd9;
  localparam logic [3:0] S_DIVG_GO   = 4'd10;
  localparam logic [3:0] S_DIVG_WAIT = 4'd11;
  localparam logic [3:0] S_EMIT_LO   = 4'd12;
  localparam logic [3:0] S_EMIT_HI   = 4'd13;
  localparam logic [3:0] S_FINISH    = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [TERM_W-1:0] term_q, term_d;

  // state and term counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      term_q  <= TERM_FIRST;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.term = term_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SELECT;
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        if (sts_i.win) begin
          term_d  = TERM_FIRST;
          state_d = S_LOG_GO;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_LOG_GO: begin
        cmd_o.log_start = 1'b1;
        state_d         = S_LOG_WAIT;
      end
      S_LOG_WAIT: begin
        if (sts_i.log_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (term_q == TERM_SUM) begin
          state_d = S_TDIFF;
        end else begin
          term_d  = term_q + TERM_W'(1);
          state_d = S_LOG_GO;
        end
      end
      S_TDIFF: begin
        cmd_o.tdiff = 1'b1;
        state_d     = S_DIVE_GO;
      end
      S_DIVE_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVE_WAIT;
      end
      S_DIVE_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store_ent = 1'b1;
          state_d         = S_DIVG_GO;
        end
      end
      S_DIVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_gc    = 1'b1;
        state_d         = S_DIVG_WAIT;
      end
      S_DIVG_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store_gc = 1'b1;
          state_d        = S_EMIT_LO;
        end
      end
      // result for the window start, while it lies below the midpoint
      S_EMIT_LO: begin
        if (!sts_i.emit_lo) begin
          state_d = S_EMIT_HI;
        end else if (sts_i.out_free) begin
          cmd_o.load_lo = 1'b1;
          state_d       = S_EMIT_HI;
        end
      end
      // result for the newest base, from the midpoint on
      S_EMIT_HI: begin
        if (!sts_i.emit_hi) begin
          state_d = S_FINISH;
        end else if (sts_i.out_free) begin
          cmd_o.load_hi = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* verif/tb_sliding_window_base_entropy_gc_top.sv */
// Self-checking testbench for the sliding-window base entropy and gc fraction block.
// It holds its own window predictor and compares every result against it.
// Depends on swegc_pkg and sliding_window_base_entropy_gc_top.
`timescale 1ns / 100ps

module tb_sliding_window_base_entropy_gc_top;
  import swegc_pkg::*;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned HIST_DEPTH    = MAX_WINDOW_DEF;
  localparam int unsigned LOG_FRAC      = 24;
  localparam int unsigned MANT_ONE      = 30;

  typedef enum logic [BASE_W-1:0] {BASE_A, BASE_C, BASE_G, BASE_T} base_e;

  // one result item as the block presents it
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [ENT_W-1:0] entropy;
    logic [GC_W-1:0]  gc_fraction;
    logic             last_of_run;
  } win_stats_t;

  // one row of the directed part; a typed row carries its single result
  typedef struct packed {
    logic             cfg;
    logic [WL_W-1:0]  wl;
    logic [SL_W-1:0]  sl;
    base_e            base;
    logic             typed;
    logic [POS_W-1:0] pos;
    logic [GC_W-1:0]  gc;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [22] = '{
    // reset setting: one-base window, one result per base, entropy zero
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b1, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_C, 1'b1, 32'd1, 17'd65536},
    '{1'b0, 8'd0, 32'd0, BASE_G, 1'b1, 32'd2, 17'd65536},
    '{1'b0, 8'd0, 32'd0, BASE_T, 1'b1, 32'd3, 17'd0},
    // four-base window, midpoint at 12: uniform, all four kinds, then both emits
    '{1'b1, 8'd4, 32'd24, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_C, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_G, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_T, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_G, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_G, 1'b0, 32'd0, 17'd0},
    // zero window register and an empty sequence length
    '{1'b1, 8'd0, 32'd0, BASE_T, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_C, 1'b0, 32'd0, 17'd0},
    // widest window, longest sequence: window not yet full, no result
    '{1'b1, 8'd255, 32'hFFFF_FFFF, BASE_G, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_T, 1'b0, 32'd0, 17'd0},
    // one-base window far below the midpoint: lower emit only
    '{1'b1, 8'd1, 32'hFFFF_FFFF, BASE_C, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_G, 1'b0, 32'd0, 17'd0},
    '{1'b0, 8'd0, 32'd0, BASE_A, 1'b0, 32'd0, 17'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [1:0] base
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] position, [47:32] entropy,
                                          // [64:48] gc_fraction
  logic                   m_axis_tlast;   // last_of_run

  // predictor state
  logic [BASE_W-1:0] hist_mem [HIST_DEPTH];
  logic [CNT_W-1:0]  base_cnt [NUM_BASES];
  logic [POS_W-1:0]  arr_idx;
  logic [WL_W-1:0]   win_len;
  logic [SL_W-1:0]   seq_len;
  win_stats_t        pending_stats_q [$];

  int unsigned fault_cnt;
  bit          idle_on;
  int unsigned rx_hold;

  sliding_window_base_entropy_gc_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always #(CLK_HALF) clk_i = ~clk_i;

  // log2 with 24 fraction bits by repeated squaring of a q1.30 mantissa
  function automatic logic [63:0] log2_q24(input int unsigned x);
    int unsigned ip;
    logic [63:0] mant;
    logic [63:0] frac;
    ip   = 0;
    frac = '0;
    if (x == 0) return '0;
    while (ip < 31 && (x >> (ip + 1)) != 0) ip++;
    mant = (64'(x) << MANT_ONE) >> ip;
    for (int k = 0; k < LOG_FRAC; k++) begin
      mant = (mant * mant) >> MANT_ONE;
      frac = frac << 1;
      if (mant >= (64'd1 << (MANT_ONE + 1))) begin
        frac[0] = 1'b1;
        mant    = mant >> 1;
      end
    end
    return (64'(ip) << LOG_FRAC) | frac;
  endfunction

  // entropy and gc fraction of the current counts
  function automatic void window_stats(output logic [ENT_W-1:0] ent,
                                       output logic [GC_W-1:0] gc);
    int unsigned s;
    logic [63:0] pos_part;
    logic [63:0] neg_part;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] cg;
    s        = 0;
    neg_part = '0;
    for (int k = 0; k < NUM_BASES; k++) s += base_cnt[k];
    if (s == 0) begin
      ent = '0;
      gc  = '0;
      return;
    end
    pos_part = 64'(s) * log2_q24(s);
    for (int k = 0; k < NUM_BASES; k++) begin
      if (base_cnt[k] != 0) neg_part += 64'(base_cnt[k]) * log2_q24(base_cnt[k]);
    end
    t = (pos_part > neg_part) ? pos_part - neg_part : 64'd0;
    e = (t + (64'(s) << ENT_ROUND_SHIFT)) / (64'(s) << ENT_SHIFT);
    if (e > 64'(ENT_MAX)) e = 64'(ENT_MAX);
    ent = e[ENT_W-1:0];
    cg  = 64'(base_cnt[BASE_C]) + 64'(base_cnt[BASE_G]);
    gc  = GC_W'((cg * 65536 + 64'(s >> 1)) / 64'(s));
  endfunction

  // advance the window by one base; optionally queue the results it causes
  function automatic void slide_window(input base_e b, input bit record);
    int unsigned w;
    logic [POS_W-1:0] mid;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] p;
    logic [ENT_W-1:0] ent;
    logic [GC_W-1:0]  gc;
    logic [BASE_W-1:0] old;
    win_stats_t res [2];
    int n;
    j   = arr_idx;
    mid = seq_len >> 1;
    w   = win_len;
    if (w > mid) w = mid;
    if (w > HIST_DEPTH) w = HIST_DEPTH;
    if (w < 1) w = 1;
    n = 0;
    hist_mem[j % HIST_DEPTH] = b;
    if (base_cnt[b] != '1) base_cnt[b] = base_cnt[b] + 1'b1;
    if (64'(j) + 1 >= 64'(w)) begin
      p = j - w + 1;
      window_stats(ent, gc);
      if (p < mid) begin
        res[n] = '{p, ent, gc, 1'b0};
        n++;
      end
      if (j >= mid) begin
        res[n] = '{j, ent, gc, 1'b0};
        n++;
      end
      if (n > 0) res[n-1].last_of_run = 1'b1;
      if (record) begin
        for (int k = 0; k < n; k++) pending_stats_q = {pending_stats_q, res[k]};
      end
      old = hist_mem[p % HIST_DEPTH];
      if (base_cnt[old] != 0) base_cnt[old] = base_cnt[old] - 1'b1;
    end
    arr_idx = j + 1;
  endfunction

  // present one base, with an optional gap before it
  task automatic send_base(input base_e b, input bit record);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(b);
    do @(posedge clk_i); while (!s_axis_tready);
    slide_window(b, record);
  endtask

  // hold the sender until every expected result is back, then let the block settle
  task automatic drain_results();
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_stats_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_stats_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_stats_q.size());
      fault_cnt++;
      pending_stats_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic load_config(input logic [WL_W-1:0] wl, input logic [SL_W-1:0] sl);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_WINDOW_LENGTH;
    cfg_wdata_i <= CFG_DATA_W'(wl);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_SEQUENCE_LENGTH;
    cfg_wdata_i <= CFG_DATA_W'(sl);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_len = wl;
    seq_len = sl;
  endtask

  // receiver with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_hold       <= 0;
      m_axis_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold       <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin
    win_stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats_q.size() == 0) begin
        $error("unexpected result for position %0d", m_axis_tdata[POS_W-1:0]);
        fault_cnt++;
      end else begin
        want = pending_stats_q.pop_front();
        if (m_axis_tdata[POS_W-1:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position,
                 m_axis_tdata[POS_W-1:0]);
          fault_cnt++;
        end
        if (m_axis_tdata[POS_W +: ENT_W] !== want.entropy) begin
          $error("entropy: expected %0d, got %0d", want.entropy,
                 m_axis_tdata[POS_W +: ENT_W]);
          fault_cnt++;
        end
        if (m_axis_tdata[POS_W + ENT_W +: GC_W] !== want.gc_fraction) begin
          $error("gc_fraction: expected %0d, got %0d", want.gc_fraction,
                 m_axis_tdata[POS_W + ENT_W +: GC_W]);
          fault_cnt++;
        end
        if (m_axis_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, m_axis_tlast);
          fault_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned mode;
    logic [WL_W-1:0] wl;
    logic [SL_W-1:0] sl;
    base_e dom;
    base_e b;
    win_stats_t typed_res;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b1;
    fault_cnt     = 0;
    arr_idx       = '0;
    win_len       = WL_RESET;
    seq_len       = SL_RESET;
    for (int k = 0; k < NUM_BASES; k++) base_cnt[k] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].cfg) load_config(DIR_ROWS[i].wl, DIR_ROWS[i].sl);
      if (DIR_ROWS[i].typed) begin
        typed_res       = '{DIR_ROWS[i].pos, '0, DIR_ROWS[i].gc, 1'b1};
        pending_stats_q = {pending_stats_q, typed_res};
      end
      send_base(DIR_ROWS[i].base, !DIR_ROWS[i].typed);
    end

    // random phases, each with its own setting and base mix
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(10, 60);
      case ($urandom_range(0, 7))
        0: wl = '0;
        1: wl = 8'd1;
        2: wl = '1;
        3: wl = WL_W'($urandom);
        default: wl = WL_W'($urandom_range(2, 40));
      endcase
      // in half the phases a midpoint that falls inside the phase, so both emits happen
      case ($urandom_range(0, 5))
        0: sl = $urandom;
        1: sl = '1;
        2: sl = SL_W'($urandom_range(0, 3));
        default: sl = 2 * arr_idx + $urandom_range(0, 2 * n);
      endcase
      mode    = $urandom_range(0, 3);
      dom     = base_e'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      // no idling over the closing stretch
      if (sent + n >= RANDOM_ITEMS) idle_on = 1'b0;
      load_config(wl, sl);
      repeat (n) begin
        case (mode)
          1: b = ($urandom_range(0, 7) != 0) ? dom : base_e'($urandom_range(0, 3));
          2: b = ($urandom_range(0, 1) != 0) ? BASE_C : BASE_G;
          3: b = ($urandom_range(0, 1) != 0) ? BASE_A : BASE_T;
          default: b = base_e'($urandom_range(0, 3));
        endcase
        send_base(b, 1'b1);
      end
      sent += n;
    end

    drain_results();
    if (fault_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/swegc_pkg.sv
hw/rtl/swegc_log2.sv
hw/rtl/swegc_div.sv
hw/rtl/swegc_dp.sv
hw/rtl/swegc_ctrl.sv
hw/rtl/sliding_window_base_entropy_gc_top.sv
verif/tb_sliding_window_base_entropy_gc_top.sv
